### rtl/core/led_breathing_wave_generator_defines.svh
// Assertion macros for the LED breathing wave generator checker.
`ifndef LED_BREATHING_WAVE_GENERATOR_DEFINES_SVH
`define LED_BREATHING_WAVE_GENERATOR_DEFINES_SVH
// Property that must hold in the cycle after the antecedent.
`define LBW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
// Property that must hold in the same cycle.
`define LBW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`endif

### rtl/core/lbw_pkg.sv
// Shared constants, types and cosine table function for the breathing generator.
package lbw_pkg;
  localparam int CosTableDepth = 1024;
  localparam int CosIdxW = $clog2(CosTableDepth);
  localparam logic [15:0] PeriodReset = 16'd30000;
  localparam logic [16:0] TriScale = 17'h1FFFE;
  localparam logic [16:0] CieOffset = 17'd2313;
  localparam logic [15:0] CieKnee = 16'd5243;
  localparam logic [63:0] CieK1 = 64'd709551112;
  localparam logic [63:0] CieK2 = 64'd127886581;
  localparam logic [63:0] Q30One = 64'd1073741824;
  localparam logic [63:0] Q30HalfPi = 64'd1686629713;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [63:0] horner(input logic [63:0] x2, input logic sel);
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] m;
    t = Q30One;
    for (int k = 0; k < 6; k++) begin
      m = (x2 * t) >> 30;
      case (k)
        0: p = sel ? m / 64'd156 : m / 64'd132;
        1: p = sel ? m / 64'd110 : m / 64'd90;
        2: p = sel ? m / 64'd72 : m / 64'd56;
        3: p = sel ? m / 64'd42 : m / 64'd30;
        4: p = sel ? m / 64'd20 : m / 64'd12;
        default: p = sel ? m / 64'd6 : m >> 1;
      endcase
      t = (p >= Q30One) ? 64'd0 : (Q30One - p);
    end
    return t;
  endfunction

  function automatic logic [15:0] cos_entry(input logic [CosIdxW-1:0] i);
    logic [63:0] q;
    logic [63:0] quad;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] v;
    q = 64'(i) * 64'd4;
    quad = (q / CosTableDepth) & 64'd3;
    x = ((q % CosTableDepth) * Q30HalfPi) / CosTableDepth;
    x2 = (x * x) >> 30;
    c = horner(x2, 1'b0);
    s = (x * horner(x2, 1'b1)) >> 30;
    m = (quad == 64'd0 || quad == 64'd2) ? c : s;
    if (m > Q30One) m = Q30One;
    r = (quad == 64'd1 || quad == 64'd2) ? (Q30One + m) : (Q30One - m);
    v = (r * 64'd65535) >> 31;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction
endpackage

### rtl/core/lbw_cos_rom.sv
// Raised cosine table, registered read.
module lbw_cos_rom (
  input  logic                        clk,
  input  logic [lbw_pkg::CosIdxW-1:0] addr,
  output logic [15:0]                 data
);
  import lbw_pkg::*;
  logic [15:0] rom [CosTableDepth];
  always_comb begin
    for (int i = 0; i < CosTableDepth; i++) rom[i] = cos_entry(CosIdxW'(i));
  end
  always_ff @(posedge clk) begin
    data <= rom[addr];
  end
endmodule

### rtl/core/lbw_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module lbw_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  lbw_pkg::div_req_t req,
  output lbw_pkg::div_rsp_t rsp
);
  import lbw_pkg::*;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  assign trial = {rem, quo[63]} - {1'b0, den};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= req.num;
        den <= req.den;
        cnt <= 7'd0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, quo};
endmodule

### rtl/core/lbw_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module lbw_serial_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  logic [63:0] mcand;
  logic [63:0] mplier;
  logic [6:0]  cnt;
  logic        busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mcand <= a;
        mplier <= b;
        prod <= '0;
        cnt <= 7'd0;
      end else if (busy) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand <= {mcand[62:0], 1'b0};
        mplier <= {1'b0, mplier[63:1]};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/core/led_breathing_wave_generator.sv
// LED breathing wave generator: one tick beat in, one duty beat out, after a
// sequence of bit-serial multiplies and divides on a shared 64-bit multiplier
// and divider. Each beat runs up to four divider passes and up to four
// multiplier passes of 64 iterations each plus issue, load and handoff, plus
// any output stall; rescale, cube and cosine steps only run when needed. The
// next beat is taken once the duty beat has been handed over.
module led_breathing_wave_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        wave_shape_we,
  input  logic        wave_shape_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] tick_delta,
  input  logic [15:0] period_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  duty
);
  import lbw_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_RSC_M = 16'h0002, S_RSC_D = 16'h0004,
    S_ADV   = 16'h0008, S_PH_D  = 16'h0010, S_AMP_M = 16'h0020,
    S_AMP_D = 16'h0040, S_COS_R = 16'h0080, S_L_SEL = 16'h0100,
    S_L_D   = 16'h0200, S_SQ_M  = 16'h0400, S_CU_M  = 16'h0800,
    S_DITH  = 16'h1000, S_OUT   = 16'h2000, S_COS_W = 16'h4000,
    S_TRI   = 16'h8000
  } state_t;

  state_t      state;
  logic        shape;
  logic [15:0] cursor;
  logic [15:0] period;
  logic [4:0]  on_left;
  logic [4:0]  off_left;
  logic [15:0] delta;
  logic [15:0] newp;
  logic [15:0] ph;
  logic [15:0] amp;
  logic [15:0] lval;
  logic [63:0] acc;
  logic [63:0] bval;
  logic        wait_op;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        mstart;
  logic [63:0] ma;
  logic [63:0] mb;
  logic        mdone;
  logic [63:0] mprod;
  logic [CosIdxW-1:0] caddr;
  logic [15:0] cdata;

  lbw_serial_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  lbw_serial_mul u_mul (.clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb),
                        .done(mdone), .prod(mprod));
  lbw_cos_rom u_rom (.clk(clk), .addr(caddr), .data(cdata));

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  logic [16:0] sum;
  logic [15:0] tval;
  logic [4:0]  on_ld;
  logic [4:0]  off_ld;
  logic [4:0]  d5;
  assign sum = {1'b0, cursor} + {1'b0, delta};
  assign tval = lval >> 8;
  assign d5 = (delta > 16'd31) ? 5'd31 : delta[4:0];
  assign on_ld = (on_left == 5'd0 && off_left == 5'd0) ? {1'b0, lval[7:4]} : on_left;
  assign off_ld = (on_left == 5'd0 && off_left == 5'd0) ?
                  (5'd16 - {1'b0, lval[7:4]}) : off_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      shape <= 1'b0;
      cursor <= '0;
      period <= PeriodReset;
      on_left <= '0;
      off_left <= '0;
      wait_op <= 1'b0;
      dreq.start <= 1'b0;
      mstart <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      mstart <= 1'b0;
      if (wave_shape_we) shape <= wave_shape_wdata;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            delta <= tick_delta;
            newp <= period_in;
            wait_op <= 1'b0;
            if (period_in != 16'd0 && period_in != period) state <= S_RSC_M;
            else state <= S_ADV;
          end
        end
        S_RSC_M: begin
          if (!wait_op) begin
            mstart <= 1'b1; ma <= 64'(cursor); mb <= 64'(newp); wait_op <= 1'b1;
          end else if (mdone) begin
            wait_op <= 1'b0; acc <= mprod; state <= S_RSC_D;
          end
        end
        S_RSC_D: begin
          if (!wait_op) begin
            dreq.start <= 1'b1; dreq.num <= acc; dreq.den <= 64'(period);
            wait_op <= 1'b1;
          end else if (drsp.done) begin
            wait_op <= 1'b0;
            cursor <= (drsp.quo > 64'd65535) ? 16'hFFFF : drsp.quo[15:0];
            period <= newp;
            state <= S_ADV;
          end
        end
        S_ADV: begin
          cursor <= (sum[15:0] >= period) ? sum[15:0] - period : sum[15:0];
          state <= S_PH_D;
        end
        S_PH_D: begin
          if (!wait_op) begin
            dreq.start <= 1'b1; dreq.num <= 64'(cursor); dreq.den <= 64'(period);
            wait_op <= 1'b1;
          end else if (drsp.done) begin
            wait_op <= 1'b0;
            ph <= cursor - drsp.quo[15:0] * period;
            state <= S_AMP_M;
          end
        end
        S_AMP_M: begin
          if (!wait_op) begin
            mstart <= 1'b1; ma <= 64'(ph);
            mb <= shape ? 64'(CosTableDepth) : 64'(TriScale);
            wait_op <= 1'b1;
          end else if (mdone) begin
            wait_op <= 1'b0; acc <= mprod; state <= S_AMP_D;
          end
        end
        S_AMP_D: begin
          if (!wait_op) begin
            dreq.start <= 1'b1; dreq.num <= acc; dreq.den <= 64'(period);
            wait_op <= 1'b1;
          end else if (drsp.done) begin
            wait_op <= 1'b0; acc <= drsp.quo;
            state <= shape ? S_COS_R : S_TRI;
          end
        end
        S_TRI: begin
          if ({15'd0, ph, 1'b0} <= 32'(period)) amp <= acc[15:0];
          else amp <= 16'(64'(TriScale) - acc);
          state <= S_L_SEL;
        end
        S_COS_R: begin
          caddr <= acc[CosIdxW-1:0];
          state <= S_COS_W;
        end
        S_COS_W: begin
          if (!wait_op) begin
            wait_op <= 1'b1;
          end else begin
            wait_op <= 1'b0; amp <= cdata; state <= S_L_SEL;
          end
        end
        S_L_SEL: begin
          if (amp <= CieKnee) begin
            acc <= 64'({1'b0, amp} + CieOffset) * 64'd1000;
            bval <= 64'd9033;
          end else begin
            acc <= ((64'({1'b0, amp} + CieOffset) << 16) + CieK1) << 16;
            bval <= CieK2;
          end
          state <= S_L_D;
        end
        S_L_D: begin
          if (!wait_op) begin
            dreq.start <= 1'b1; dreq.num <= acc; dreq.den <= bval; wait_op <= 1'b1;
          end else if (drsp.done) begin
            wait_op <= 1'b0;
            if (amp <= CieKnee) begin
              lval <= drsp.quo[15:0]; state <= S_DITH;
            end else begin
              bval <= drsp.quo; state <= S_SQ_M;
            end
          end
        end
        S_SQ_M: begin
          if (!wait_op) begin
            mstart <= 1'b1; ma <= bval; mb <= bval; wait_op <= 1'b1;
          end else if (mdone) begin
            wait_op <= 1'b0; acc <= mprod >> 16; state <= S_CU_M;
          end
        end
        S_CU_M: begin
          if (!wait_op) begin
            mstart <= 1'b1; ma <= acc; mb <= bval; wait_op <= 1'b1;
          end else if (mdone) begin
            wait_op <= 1'b0;
            lval <= ((mprod >> 32) > 64'd65535) ? 16'hFFFF : mprod[47:32];
            state <= S_DITH;
          end
        end
        S_DITH: begin
          if (delta > 16'd2 || tval == 16'd255) begin
            duty <= tval[7:0];
          end else if (on_ld != 5'd0) begin
            on_left <= (d5 <= on_ld) ? on_ld - d5 : 5'd0;
            off_left <= off_ld;
            duty <= tval[7:0] + 8'd1;
          end else begin
            on_left <= on_ld;
            off_left <= (d5 <= off_ld) ? off_ld - d5 : 5'd0;
            duty <= tval[7:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/lbw_checker.sv
// Port-level checker for the breathing generator, bound to the top level.
`include "led_breathing_wave_generator_defines.svh"
module lbw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] duty
);
  `LBW_ASSERT_NOW(a_no_in_while_out, out_valid, in_stall)
  `LBW_ASSERT_NEXT(a_in_starts_work, in_valid && !in_stall, in_stall && !out_valid)
  `LBW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(duty))
  `LBW_ASSERT_NEXT(a_out_once, out_valid && !out_stall, !out_valid)
endmodule

bind led_breathing_wave_generator lbw_checker u_lbw_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .duty(duty)
);

### tb/led_breathing_wave_generator_tb.sv
// Testbench for the LED breathing wave generator: directed and random ticks against a predictor.
module led_breathing_wave_generator_tb;
  import lbw_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wave_shape_we = 1'b0;
  logic        wave_shape_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] tick_delta = '0;
  logic [15:0] period_in = 16'd1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  duty;

  led_breathing_wave_generator dut (
    .clk(clk), .rst(rst),
    .wave_shape_we(wave_shape_we), .wave_shape_wdata(wave_shape_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .tick_delta(tick_delta), .period_in(period_in),
    .out_valid(out_valid), .out_stall(out_stall), .duty(duty)
  );

  always #1 clk = ~clk;

  // predictor state
  logic        shape_q;
  logic [15:0] cursor_q;
  logic [15:0] period_q;
  logic [4:0]  dith_on_q;
  logic [4:0]  dith_off_q;

  logic [7:0] duty_q[$];
  int  errors = 0;
  bit  no_idle = 1'b0;
  int  hold_cycles = 0;

  function automatic longint unsigned taylor(longint unsigned x2, bit is_sin);
    longint unsigned acc, p, dv;
    acc = Q30One;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: dv = is_sin ? 156 : 132;
        1: dv = is_sin ? 110 : 90;
        2: dv = is_sin ? 72 : 56;
        3: dv = is_sin ? 42 : 30;
        4: dv = is_sin ? 20 : 12;
        default: dv = is_sin ? 6 : 2;
      endcase
      p = ((x2 * acc) >> 30) / dv;
      acc = (p >= Q30One) ? 64'd0 : Q30One - p;
    end
    return acc;
  endfunction

  function automatic logic [15:0] cosine_amp(longint unsigned idx);
    longint unsigned q, quad, x, x2, m, r, v;
    q = (idx % CosTableDepth) * 4;
    quad = (q / CosTableDepth) & 3;
    x = ((q % CosTableDepth) * Q30HalfPi) / CosTableDepth;
    x2 = (x * x) >> 30;
    m = (quad == 0 || quad == 2) ? taylor(x2, 1'b0) : (x * taylor(x2, 1'b1)) >> 30;
    if (m > Q30One) m = Q30One;
    r = (quad == 1 || quad == 2) ? Q30One + m : Q30One - m;
    v = (r * 65535) >> 31;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] cie_lightness(logic [15:0] amp);
    longint unsigned adj, b, sq, cube;
    adj = longint'(amp) + 2313;
    if (amp <= 16'd5243) return 16'((adj * 1000) / 9033);
    b = (((adj << 16) + CieK1) << 16) / CieK2;
    sq = (b * b) >> 16;
    cube = ((sq * b) >> 16) >> 16;
    return (cube > 65535) ? 16'hFFFF : cube[15:0];
  endfunction

  function automatic logic [7:0] next_duty(logic [15:0] delta, logic [15:0] per);
    longint unsigned sc, ph, disp;
    logic [15:0] amp, lt;
    logic [7:0]  top;
    if (per != 0 && per != period_q) begin
      sc = (longint'(cursor_q) * per) / period_q;
      cursor_q = (sc > 65535) ? 16'hFFFF : sc[15:0];
      period_q = per;
    end
    cursor_q = cursor_q + delta;
    if (cursor_q >= period_q) cursor_q = cursor_q - period_q;
    ph = longint'(cursor_q) % period_q;
    if (shape_q) begin
      amp = cosine_amp((ph * CosTableDepth) / period_q);
    end else begin
      disp = (ph * 64'h1FFFE) / period_q;
      amp = (2 * ph <= period_q) ? disp[15:0] : 16'(64'h1FFFE - disp);
    end
    lt = cie_lightness(amp);
    top = lt[15:8];
    if (delta > 2 || top == 8'hFF) return top;
    if (dith_on_q == 0 && dith_off_q == 0) begin
      dith_on_q = {1'b0, lt[7:4]};
      dith_off_q = 5'd16 - dith_on_q;
    end
    if (dith_on_q != 0) begin
      dith_on_q = (delta <= dith_on_q) ? dith_on_q - delta[4:0] : 5'd0;
      return top + 8'd1;
    end
    dith_off_q = (delta <= dith_off_q) ? dith_off_q - delta[4:0] : 5'd0;
    return top;
  endfunction

  task automatic send_tick(logic [15:0] delta, logic [15:0] per);
    int gap;
    if (!no_idle && $urandom_range(99) < 34) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    tick_delta <= delta;
    period_in <= per;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    duty_q.push_back(next_duty(delta, per));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (duty_q.size() == 0);
    repeat (1000) @(posedge clk);
  endtask

  task automatic set_shape(logic v);
    drain();
    @(negedge clk);
    wave_shape_we <= 1'b1;
    wave_shape_wdata <= v;
    @(negedge clk);
    wave_shape_we <= 1'b0;
    shape_q = v;
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (duty_q.size() == 0) begin
        $display("%0t: unexpected duty beat, actual %0d", $time, duty);
        errors++;
      end else begin
        if (duty !== duty_q[0]) begin
          $display("%0t: duty mismatch, expected %0d actual %0d", $time, duty_q[0], duty);
          errors++;
        end
        void'(duty_q.pop_front());
      end
    end
  end

  task automatic test_directed_triangle();
    send_tick(16'd0, 16'd30000);
    send_tick(16'd1, 16'd30000);
    send_tick(16'd2, 16'd30000);
    send_tick(16'd3, 16'd30000);
    send_tick(16'd15000, 16'd30000);
    send_tick(16'd65535, 16'd30000);
    send_tick(16'd100, 16'd0);
    send_tick(16'd7, 16'd1);
    send_tick(16'd0, 16'd65535);
    send_tick(16'd65535, 16'd65535);
    send_tick(16'd32767, 16'd2);
    send_tick(16'd1, 16'd65535);
    send_tick(16'hAAAA, 16'h5555);
    send_tick(16'h5555, 16'hAAAA);
  endtask

  task automatic test_directed_cosine();
    send_tick(16'd0, 16'd1024);
    send_tick(16'd256, 16'd1024);
    send_tick(16'd256, 16'd1024);
    send_tick(16'd256, 16'd1024);
    send_tick(16'd1, 16'd3);
    send_tick(16'd2, 16'd0);
    send_tick(16'd65535, 16'd40000);
    send_tick(16'd0, 16'd65535);
    send_tick(16'd1, 16'd65535);
  endtask

  task automatic test_receiver_hold();
    hold_cycles <= 3000;
    repeat (6) send_tick(16'($urandom_range(0, 3)), 16'd2000);
  endtask

  task automatic test_random(int count);
    logic [15:0] per, d, p;
    int r;
    per = 16'($urandom_range(1, 65535));
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 6) per = 16'($urandom_range(1, 65535));
      else if (r < 10) per = 16'($urandom_range(1, 64));
      r = $urandom_range(99);
      if (r < 60) d = 16'($urandom_range(0, 2));
      else if (r < 85) d = 16'($urandom_range(3, 200));
      else d = 16'($urandom);
      r = $urandom_range(99);
      p = (r < 4) ? 16'd0 : (r < 8) ? 16'($urandom) : per;
      send_tick(d, p);
    end
  endtask

  initial begin
    shape_q = 1'b0;
    cursor_q = '0;
    period_q = PeriodReset;
    dith_on_q = '0;
    dith_off_q = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_triangle();
    set_shape(1'b1);
    test_directed_cosine();
    test_receiver_hold();
    test_random(250);
    set_shape(1'b0);
    test_random(250);
    no_idle = 1'b1;
    test_random(150);
    no_idle = 1'b0;
    set_shape(1'b1);
    test_random(250);
    set_shape(1'b0);
    test_random(120);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/lbw_pkg.sv
rtl/core/lbw_cos_rom.sv
rtl/core/lbw_serial_div.sv
rtl/core/lbw_serial_mul.sv
rtl/core/led_breathing_wave_generator.sv
rtl/core/lbw_checker.sv
tb/led_breathing_wave_generator_tb.sv
